// File: rtl/mrrp_pkg.sv
// shared types, constants and the crc16 byte step for the modbus read response parser
// no dependencies; imported by every module of the block
package mrrp_pkg;

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  BYTE_COUNT = 8'h04;

    // input opcodes
    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_STATION_ID    = 2'd0;
    localparam logic [1:0] CFG_FUNCTION_CODE = 2'd1;
    localparam logic [1:0] CFG_RESYNC_TICKS  = 2'd2;
    localparam logic [1:0] CFG_SWAP_WORDS    = 2'd3;

    // hunt phases: header bytes, value bytes, then the two crc bytes
    localparam logic [3:0] PH_STATION     = 4'd0;
    localparam logic [3:0] PH_FUNCTION    = 4'd1;
    localparam logic [3:0] PH_BYTE_COUNT  = 4'd2;
    localparam logic [3:0] PH_VALUE_FIRST = 4'd3;
    localparam logic [3:0] PH_CRC_LOW     = 4'd7;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  station_id;
        logic [7:0]  function_code;
        logic [15:0] resync_ticks;
        logic        swap_words;
        logic [15:0] hdr_crc;
    } cfg_t;

    typedef struct packed {
        logic        status;
        logic [31:0] value_bits;
        logic [15:0] crc_computed;
        logic [15:0] crc_received;
        logic        swapped_order;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/modbus_read_response_parser.sv
// modbus rtu read response parser, top level: config registers, header crc and assertions
// depends on mrrp_pkg, mrrp_in_reg, mrrp_core, mrrp_out_reg
//
// Accepts one beat per clock: s_tuser carries the opcode (data byte, millisecond tick, clear)
// and s_tdata the received byte. Each beat passes an input register, is handled by the
// parser core once the output register is free and, when it completes a frame (station,
// function, byte count 4, four value bytes, crc low, crc high), leaves one result in the
// output register. A stalled sink holds the pipe, otherwise the rate is one beat per
// cycle, set by the single crc byte step in the core. The crc of the three header bytes
// is kept in a three-stage pipeline fed by the station and function registers: crc1_reg,
// crc2_reg, then hdr_crc_reg. There is no clearing pass after reset.
module modbus_read_response_parser
    import mrrp_pkg::*;
#(
    parameter int BUFFER_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // value_bits[31:0], crc_computed[47:32], crc_received[63:48]
    output logic [1:0]  m_tuser,   // status[0], swapped_order[1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [7:0]  station_reg;
    logic [7:0]  function_reg;
    logic [15:0] resync_reg;
    logic        swap_reg;
    logic [15:0] crc1_reg;
    logic [15:0] crc2_reg;
    logic [15:0] hdr_crc_reg;

    cfg_t     cfg;
    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     item_fire;
    logic     out_free;
    logic     res_valid;
    logic     res_load;
    result_t  res;
    result_t  result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg  <= 8'd1;
            function_reg <= 8'd3;
            resync_reg   <= 16'd200;
            swap_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STATION_ID:    station_reg  <= cfg_data[7:0];
                CFG_FUNCTION_CODE: function_reg <= cfg_data[7:0];
                CFG_RESYNC_TICKS:  resync_reg   <= cfg_data;
                CFG_SWAP_WORDS:    swap_reg     <= cfg_data[0];
            endcase
        end
    end

    // header crc, one byte step per stage
    always_ff @(posedge clk)
    begin
        crc1_reg    <= crc_byte(CRC_PRESET, station_reg);
        crc2_reg    <= crc_byte(crc1_reg, function_reg);
        hdr_crc_reg <= crc_byte(crc2_reg, BYTE_COUNT);
    end

    always_comb
    begin
        cfg.station_id    = station_reg;
        cfg.function_code = function_reg;
        cfg.resync_ticks  = resync_reg;
        cfg.swap_words    = swap_reg;
        cfg.hdr_crc       = hdr_crc_reg;
    end

    assign in_item.op   = s_tuser;
    assign in_item.data = s_tdata;
    assign item_fire    = item_valid && out_free;
    assign res_load     = item_fire && res_valid;

    mrrp_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_item    (in_item),
        .take       (item_fire),
        .item_valid (item_valid),
        .item       (item)
    );

    mrrp_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_fire (item_fire),
        .item      (item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    mrrp_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    assign m_tdata = {result.crc_received, result.crc_computed, result.value_bits};
    assign m_tuser = {result.swapped_order, result.status};

    // status must agree with the two crcs it reports
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] == (m_tdata[47:32] != m_tdata[63:48])))
        else $error("status does not match crc comparison");

    // input side only stalls while a beat is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> item_valid)
        else $error("s_tready low with empty input register");

    // a new result never overwrites one the sink has not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

endmodule

// File: rtl/mrrp_in_reg.sv
// input register of the parser: holds one accepted beat until the core takes it
// depends on mrrp_pkg
module mrrp_in_reg
    import mrrp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_item_t in_item,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: rtl/mrrp_core.sv
// frame hunting, value collection, crc update and idle timeout, one beat per item_fire cycle
// depends on mrrp_pkg
module mrrp_core
    import mrrp_pkg::*;
#(
    parameter int BUFFER_BYTES = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_fire,
    input  in_item_t item,
    input  cfg_t     cfg,
    output logic     res_valid,
    output result_t  res
);

    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);

    logic [3:0]        phase_reg, phase_next;
    logic [31:0]       value_reg, value_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        crc_low_reg, crc_low_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       idle_reg, idle_next;

    logic        do_empty;
    logic [15:0] idle_inc;
    logic [15:0] rcv;
    logic        bad;
    logic [7:0]  expected;

    assign idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign rcv      = {item.data, crc_low_reg};
    assign bad      = rcv != crc_reg;

    always_comb
    begin
        if (phase_reg == PH_STATION)
        begin
            expected = cfg.station_id;
        end
        else if (phase_reg == PH_FUNCTION)
        begin
            expected = cfg.function_code;
        end
        else
        begin
            expected = BYTE_COUNT;
        end
    end

    always_comb
    begin
        res.status        = bad;
        res.value_bits    = cfg.swap_words ? {value_reg[15:0], value_reg[31:16]} : value_reg;
        res.crc_computed  = crc_reg;
        res.crc_received  = rcv;
        res.swapped_order = cfg.swap_words;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        value_next   = value_reg;
        crc_next     = crc_reg;
        crc_low_next = crc_low_reg;
        fill_next    = fill_reg;
        idle_next    = idle_reg;
        do_empty     = 1'b0;
        res_valid    = 1'b0;
        if (item_fire)
        begin
            unique case (item.op)
                OP_TICK:
                begin
                    if (fill_reg != '0)
                    begin
                        idle_next = idle_inc;
                        if (idle_inc > cfg.resync_ticks)
                        begin
                            do_empty = 1'b1;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    do_empty = 1'b1;
                end
                OP_DATA:
                begin
                    idle_next = '0;
                    // a full buffer drops the beat
                    if (fill_reg < FILL_W'(BUFFER_BYTES))
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                        if (phase_reg < PH_VALUE_FIRST)
                        begin
                            if (item.data == expected)
                            begin
                                phase_next = phase_reg + 4'd1;
                                if (phase_reg == PH_BYTE_COUNT)
                                begin
                                    crc_next   = cfg.hdr_crc;
                                    value_next = '0;
                                end
                            end
                            // mismatch: fall back to the longest suffix that is a header prefix
                            else if (phase_reg == PH_BYTE_COUNT &&
                                     cfg.function_code == cfg.station_id &&
                                     item.data == cfg.function_code)
                            begin
                                phase_next = PH_BYTE_COUNT;
                            end
                            else if (phase_reg != PH_STATION && item.data == cfg.station_id)
                            begin
                                phase_next = PH_FUNCTION;
                            end
                            else
                            begin
                                phase_next = PH_STATION;
                            end
                        end
                        else if (phase_reg < PH_CRC_LOW)
                        begin
                            crc_next   = crc_byte(crc_reg, item.data);
                            value_next = {value_reg[23:0], item.data};
                            phase_next = phase_reg + 4'd1;
                        end
                        else if (phase_reg == PH_CRC_LOW)
                        begin
                            crc_low_next = item.data;
                            phase_next   = phase_reg + 4'd1;
                        end
                        else
                        begin
                            res_valid    = 1'b1;
                            phase_next   = PH_STATION;
                            crc_next     = CRC_PRESET;
                            value_next   = '0;
                            crc_low_next = '0;
                            // a bad frame keeps its bytes counted
                            if (!bad)
                            begin
                                fill_next = '0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (do_empty)
        begin
            phase_next   = PH_STATION;
            value_next   = '0;
            crc_next     = CRC_PRESET;
            crc_low_next = '0;
            fill_next    = '0;
            idle_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_STATION;
            value_reg   <= '0;
            crc_reg     <= CRC_PRESET;
            crc_low_reg <= '0;
            fill_reg    <= '0;
            idle_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            value_reg   <= value_next;
            crc_reg     <= crc_next;
            crc_low_reg <= crc_low_next;
            fill_reg    <= fill_next;
            idle_reg    <= idle_next;
        end
    end

endmodule

// File: rtl/mrrp_out_reg.sv
// result register of the parser: holds one finished result until the sink takes it
// depends on mrrp_pkg
module mrrp_out_reg
    import mrrp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    out_free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign result   = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= res;
        end
    end

endmodule
